// File: src/cau_pkg.sv
// Shared codes and types for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // Side information that rides along the divider stages.
  typedef struct packed {
    logic dz;
    logic neg_re;
    logic neg_im;
  } cau_tag_t;

endpackage
`default_nettype wire

// File: src/complex_arith_unit.sv
// Top level of the complex arithmetic unit (add, subtract, multiply, divide).
//
// Usage: drive in_command and the four operand components with start high;
// busy is always low, so a transaction is taken on every cycle start is high.
// Operands are signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction.
// Each transaction yields exactly one result, shown for one cycle with
// out_valid high, in input order. The receiver cannot stall, and the block
// never needs to: it is fully pipelined and takes one transaction per cycle.
// Every command takes the same path through all stages. The divider is the
// longest part: one quotient bit per stage, DATA_WIDTH+1 stages. Ahead of
// it are an input register, a product stage, a combine stage and a
// magnitude/setup stage; behind it one saturating output stage.
// Non-divide commands also pass the divider with a denominator of 2^FRAC_BITS,
// which returns the magnitude unchanged and flags wide values for saturation.
// Reset (rst_n low, synchronous) clears the valid bits; data in flight is lost.
// Status: 0 ok, 1 saturated, 2 divide by zero (result components zero).
`default_nettype none
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_command,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_real,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_imag,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_real,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_imag,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_res_real,
  output logic signed [DATA_WIDTH-1:0]      out_res_imag,
  output logic [1:0]                        out_status
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 1;
  localparam int MW = DW + 2;

  assign busy = 1'b0;

  // stage 1: input register
  logic                 v1_r;
  logic [1:0]           cmd1_r;
  logic signed [DW-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    cmd1_r <= in_command;
    ar1_r  <= in_a_real;
    ai1_r  <= in_a_imag;
    br1_r  <= in_b_real;
    bi1_r  <= in_b_imag;
  end

  // stage 2: products and component sums
  logic                 v2_r;
  logic [1:0]           cmd2_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_bb_r_r, p_bb_i_r;
  logic signed [DW:0]   as_re_r, as_im_r;
  logic signed [DW:0]   as_re_nxt, as_im_nxt;

  always_comb begin
    if (cmd1_r == CMD_SUB) begin
      as_re_nxt = (DW+1)'(ar1_r) - (DW+1)'(br1_r);
      as_im_nxt = (DW+1)'(ai1_r) - (DW+1)'(bi1_r);
    end else begin
      as_re_nxt = (DW+1)'(ar1_r) + (DW+1)'(br1_r);
      as_im_nxt = (DW+1)'(ai1_r) + (DW+1)'(bi1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    cmd2_r   <= cmd1_r;
    p_rr_r   <= ar1_r * br1_r;
    p_ii_r   <= ai1_r * bi1_r;
    p_ir_r   <= ai1_r * br1_r;
    p_ri_r   <= ar1_r * bi1_r;
    p_bb_r_r <= br1_r * br1_r;
    p_bb_i_r <= bi1_r * bi1_r;
    as_re_r  <= as_re_nxt;
    as_im_r  <= as_im_nxt;
  end

  // stage 3: combine into signed numerators and the denominator
  logic                 v3_r;
  logic [1:0]           cmd3_r;
  logic signed [SW-1:0] sum_re_r, sum_im_r, sum_re_nxt, sum_im_nxt;
  logic [PW-1:0]        den3_r;

  always_comb begin
    case (cmd2_r)
      CMD_MUL: begin
        sum_re_nxt = SW'(p_rr_r) - SW'(p_ii_r);
        sum_im_nxt = SW'(p_ir_r) + SW'(p_ri_r);
      end
      CMD_DIV: begin
        sum_re_nxt = SW'(p_rr_r) + SW'(p_ii_r);
        sum_im_nxt = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        sum_re_nxt = SW'(as_re_r);
        sum_im_nxt = SW'(as_im_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    cmd3_r   <= cmd2_r;
    sum_re_r <= sum_re_nxt;
    sum_im_r <= sum_im_nxt;
    // squares are non-negative, sum fits in PW bits
    den3_r   <= PW'(p_bb_r_r) + PW'(p_bb_i_r);
  end

  // stage 4: sign/magnitude split and divider setup
  logic          v4_r;
  logic [PW-1:0] num_re_r, num_im_r, den4_r;
  cau_tag_t      tag4_r;
  logic [SW-1:0] abs_re, abs_im;
  logic [PW-1:0] num_re_nxt, num_im_nxt, den4_nxt;
  cau_tag_t      tag4_nxt;

  always_comb begin
    abs_re = sum_re_r[SW-1] ? SW'(-sum_re_r) : SW'(sum_re_r);
    abs_im = sum_im_r[SW-1] ? SW'(-sum_im_r) : SW'(sum_im_r);
    num_re_nxt = abs_re[PW-1:0];
    num_im_nxt = abs_im[PW-1:0];
    if (cmd3_r == CMD_MUL) begin
      // truncation toward zero on the magnitude
      num_re_nxt = abs_re[PW-1:0] >> FRAC_BITS;
      num_im_nxt = abs_im[PW-1:0] >> FRAC_BITS;
    end
    // unit scale for non-divide commands
    den4_nxt        = (cmd3_r == CMD_DIV) ? den3_r : (PW'(1) << FRAC_BITS);
    tag4_nxt.dz     = (cmd3_r == CMD_DIV) && (den3_r == '0);
    tag4_nxt.neg_re = sum_re_r[SW-1];
    tag4_nxt.neg_im = sum_im_r[SW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    num_re_r <= num_re_nxt;
    num_im_r <= num_im_nxt;
    den4_r   <= den4_nxt;
    tag4_r   <= tag4_nxt;
  end

  // divider stages
  logic          dv_valid;
  logic [MW-1:0] dv_q_re, dv_q_im;
  cau_tag_t      dv_tag;

  cau_div_pipe #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_num_re (num_re_r),
    .in_num_im (num_im_r),
    .in_den    (den4_r),
    .in_tag    (tag4_r),
    .out_valid (dv_valid),
    .out_q_re  (dv_q_re),
    .out_q_im  (dv_q_im),
    .out_tag   (dv_tag)
  );

  // output stage: saturate and encode
  localparam logic [MW-1:0] HALF = MW'(1) << (DW - 1);

  logic          out_valid_r;
  logic [DW-1:0] res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          sat_re, sat_im;
  logic [MW-1:0] mag_re, mag_im;

  always_comb begin
    mag_re = dv_q_re;
    sat_re = 1'b0;
    if (dv_tag.neg_re) begin
      if (dv_q_re > HALF) begin
        mag_re = HALF;
        sat_re = 1'b1;
      end
      res_re_nxt = DW'(-mag_re);
    end else begin
      if (dv_q_re > HALF - MW'(1)) begin
        mag_re = HALF - MW'(1);
        sat_re = 1'b1;
      end
      res_re_nxt = mag_re[DW-1:0];
    end

    mag_im = dv_q_im;
    sat_im = 1'b0;
    if (dv_tag.neg_im) begin
      if (dv_q_im > HALF) begin
        mag_im = HALF;
        sat_im = 1'b1;
      end
      res_im_nxt = DW'(-mag_im);
    end else begin
      if (dv_q_im > HALF - MW'(1)) begin
        mag_im = HALF - MW'(1);
        sat_im = 1'b1;
      end
      res_im_nxt = mag_im[DW-1:0];
    end

    status_nxt = (sat_re || sat_im) ? ST_SAT : ST_OK;
    if (dv_tag.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    status_r <= status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_res_real = res_re_r;
  assign out_res_imag = res_im_r;
  assign out_status   = status_r;

endmodule
`default_nettype wire

// File: src/cau_div_pipe.sv
// Pipelined restoring divider: two numerators over one shared denominator.
`default_nettype none
module cau_div_pipe import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [2*DATA_WIDTH-1:0] in_num_re,
  input  wire logic [2*DATA_WIDTH-1:0] in_num_im,
  input  wire logic [2*DATA_WIDTH-1:0] in_den,
  input  wire cau_tag_t                in_tag,
  output logic                         out_valid,
  output logic [DATA_WIDTH+1:0]        out_q_re,
  output logic [DATA_WIDTH+1:0]        out_q_im,
  output cau_tag_t                     out_tag
);

  localparam int DW   = DATA_WIDTH;
  localparam int DENW = 2 * DW;
  localparam int RW   = 2 * DW + FRAC_BITS;
  localparam int QW   = DW + 1;
  localparam int NST  = DW + 1;

  logic            valid_r  [NST];
  logic [RW-1:0]   rem_re_r [NST];
  logic [RW-1:0]   rem_im_r [NST];
  logic [QW-1:0]   q_re_r   [NST];
  logic [QW-1:0]   q_im_r   [NST];
  logic            ovf_re_r [NST];
  logic            ovf_im_r [NST];
  logic [DENW-1:0] den_r    [NST];
  cau_tag_t        tag_r    [NST];

  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_stage
      localparam int K = DW - s;
      logic            v_in;
      logic [RW-1:0]   rr_in, ri_in, rr_nxt, ri_nxt, den_x;
      logic [QW-1:0]   qr_in, qi_in, qr_nxt, qi_nxt;
      logic            or_in, oi_in;
      logic [DENW-1:0] den_in;
      cau_tag_t        tag_in;

      if (s == 0) begin : g_first
        assign v_in   = in_valid;
        assign rr_in  = RW'(in_num_re) << FRAC_BITS;
        assign ri_in  = RW'(in_num_im) << FRAC_BITS;
        assign qr_in  = '0;
        assign qi_in  = '0;
        assign den_in = in_den;
        assign tag_in = in_tag;
        // quotient would need more than QW bits
        assign or_in  = (rr_in >> QW) >= RW'(in_den);
        assign oi_in  = (ri_in >> QW) >= RW'(in_den);
      end else begin : g_next
        assign v_in   = valid_r[s-1];
        assign rr_in  = rem_re_r[s-1];
        assign ri_in  = rem_im_r[s-1];
        assign qr_in  = q_re_r[s-1];
        assign qi_in  = q_im_r[s-1];
        assign den_in = den_r[s-1];
        assign tag_in = tag_r[s-1];
        assign or_in  = ovf_re_r[s-1];
        assign oi_in  = ovf_im_r[s-1];
      end

      assign den_x = RW'(den_in);

      always_comb begin
        rr_nxt = rr_in;
        qr_nxt = qr_in;
        if ((rr_in >> K) >= den_x) begin
          rr_nxt = rr_in - (den_x << K);
          qr_nxt = qr_in | (QW'(1) << K);
        end
        ri_nxt = ri_in;
        qi_nxt = qi_in;
        if ((ri_in >> K) >= den_x) begin
          ri_nxt = ri_in - (den_x << K);
          qi_nxt = qi_in | (QW'(1) << K);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else begin
          valid_r[s] <= v_in;
        end
        rem_re_r[s] <= rr_nxt;
        rem_im_r[s] <= ri_nxt;
        q_re_r[s]   <= qr_nxt;
        q_im_r[s]   <= qi_nxt;
        ovf_re_r[s] <= or_in;
        ovf_im_r[s] <= oi_in;
        den_r[s]    <= den_in;
        tag_r[s]    <= tag_in;
      end
    end
  endgenerate

  assign out_valid = valid_r[NST-1];
  assign out_q_re  = {ovf_re_r[NST-1], q_re_r[NST-1]};
  assign out_q_im  = {ovf_im_r[NST-1], q_im_r[NST-1]};
  assign out_tag   = tag_r[NST-1];

endmodule
`default_nettype wire

// File: tb/cau_checker.sv
// Scoreboard for the complex arithmetic unit: predicts each result and compares.
module cau_checker import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_a_real,
  input  logic signed [15:0] in_a_imag,
  input  logic signed [15:0] in_b_real,
  input  logic signed [15:0] in_b_imag,
  input  logic               out_valid,
  input  logic signed [15:0] out_res_real,
  input  logic signed [15:0] out_res_imag,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [1:0]         st;
  } cplx_result_t;

  cplx_result_t expected_q[$];

  // saturate to 16 bits
  function automatic logic signed [15:0] clamp16(input longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  function automatic longint trunc_div(input longint n, input longint d);
    longint m;
    m = (n < 0 ? -n : n) / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic cplx_result_t compute_result(input logic [1:0] cmd,
      input longint ar, input longint ai, input longint br, input longint bi);
    cplx_result_t r;
    longint re;
    longint im;
    longint den;
    logic sat;
    sat = 1'b0;
    case (cmd)
      CMD_ADD: begin re = ar + br; im = ai + bi; end
      CMD_SUB: begin re = ar - br; im = ai - bi; end
      CMD_MUL: begin
        re = trunc_div(ar * br - ai * bi, 256);
        im = trunc_div(ai * br + ar * bi, 256);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.re = '0;
          r.im = '0;
          r.st = ST_DZ;
          return r;
        end
        // numerators fit 33 bits; shifted by 8 still fits 64
        re = trunc_div((ar * br + ai * bi) * 256, den);
        im = trunc_div((ai * br - ar * bi) * 256, den);
      end
    endcase
    r.re = clamp16(re, sat);
    r.im = clamp16(im, sat);
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  initial fail_count = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (rst_n && start && !busy)
      expected_q.push_back(compute_result(in_command, in_a_real, in_a_imag,
                                          in_b_real, in_b_imag));
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result re=%0d im=%0d st=%0d",
                   out_res_real, out_res_imag, out_status);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.re !== out_res_real || exp_r.im !== out_res_imag ||
            exp_r.st !== out_status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                     exp_r.re, exp_r.im, exp_r.st,
                     out_res_real, out_res_imag, out_status);
        end
      end
    end
  end
endmodule

// File: tb/tb.sv
// Testbench top: stimulus for the complex arithmetic unit and the verdict.
module tb import cau_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 22;
  localparam int MAX_CYCLE = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_command = CMD_ADD;
  logic signed [15:0] in_a_real = '0;
  logic signed [15:0] in_a_imag = '0;
  logic signed [15:0] in_b_real = '0;
  logic signed [15:0] in_b_imag = '0;
  logic               out_valid;
  logic signed [15:0] out_res_real;
  logic signed [15:0] out_res_imag;
  logic [1:0]         out_status;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;

  always #10 clk = ~clk;

  complex_arith_unit dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_a_real, .in_a_imag,
    .in_b_real, .in_b_imag, .out_valid, .out_res_real, .out_res_imag, .out_status
  );

  cau_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_command, .in_a_real, .in_a_imag,
    .in_b_real, .in_b_imag, .out_valid, .out_res_real, .out_res_imag,
    .out_status, .fail_count, .pending
  );

  // Watchdog: a hung pipeline must not hang the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Pick an operand: mostly random, sometimes an edge value.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic issue_op(input logic [1:0] cmd, input logic [15:0] ar,
                          input logic [15:0] ai, input logic [15:0] br,
                          input logic [15:0] bi);
    start      <= 1'b1;
    in_command <= cmd;
    in_a_real  <= ar;
    in_a_imag  <= ai;
    in_b_real  <= br;
    in_b_imag  <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Optional idle gap; start drops only when a gap actually follows.
  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] ext [4];
    int burst;
    ext = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes on every command, divide by zero, exact values.
    for (int c = 0; c < 4; c++) begin
      issue_op(c[1:0], 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      issue_op(c[1:0], 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      issue_op(c[1:0], 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
      issue_op(c[1:0], 16'h0100, 16'hff00, 16'h0200, 16'h0080);
    end
    issue_op(CMD_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    issue_op(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    issue_op(CMD_DIV, 16'h8000, 16'h0000, 16'h0000, 16'hffff);
    issue_op(CMD_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h8000);
    issue_op(CMD_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
    issue_op(CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    idle_gap();

    // Random part, in bursts so gaps fall at every pipeline phase.
    for (int i = 0; i < 1050; i++) begin
      burst = $urandom_range(0, 9);
      issue_op(2'($urandom_range(0, 3)),
               (burst == 0) ? ext[$urandom_range(0, 3)] : pick_operand(),
               pick_operand(), pick_operand(),
               (burst == 1) ? 16'h0000 : pick_operand());
      if (i % 200 < 150) idle_gap();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule
